[rtl/lrs_pkg.sv]
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared types and constants for the load relay sequencer: register map,
// field widths, reset values, load modes and fixed relay delays.
// ----------------------------------------------------------------------------
package lrs_pkg;

   // field widths
   localparam int VoltW  = 13;
   localparam int AmpW   = 12;
   localparam int DelayW = 16;
   localparam int ModeW  = 2;

   // configuration port
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;

   // default countdown width
   localparam int DELAY_WIDTH_DEFAULT = 16;

   // register indexes
   localparam logic [CsrIndexW-1:0] RegEmergencyVoltage = 3'd0;
   localparam logic [CsrIndexW-1:0] RegLowVoltage       = 3'd1;
   localparam logic [CsrIndexW-1:0] RegReleaseVoltage   = 3'd2;
   localparam logic [CsrIndexW-1:0] RegCurrentThreshold = 3'd3;
   localparam logic [CsrIndexW-1:0] RegSourceOnDelay    = 3'd4;
   localparam logic [CsrIndexW-1:0] RegLoadOnDelay      = 3'd5;
   localparam logic [CsrIndexW-1:0] RegSourceOffDelay   = 3'd6;

   // register reset values
   localparam logic [VoltW-1:0]  EmergencyVoltageRst = 13'd2340;
   localparam logic [VoltW-1:0]  LowVoltageRst       = 13'd2460;
   localparam logic [VoltW-1:0]  ReleaseVoltageRst   = 13'd2640;
   localparam logic [AmpW-1:0]   CurrentThresholdRst = 12'd50;
   localparam logic [DelayW-1:0] SourceOnDelayRst    = 16'd100;
   localparam logic [DelayW-1:0] LoadOnDelayRst      = 16'd8000;
   localparam logic [DelayW-1:0] SourceOffDelayRst   = 16'd10000;

   // load modes
   localparam logic [ModeW-1:0] ModeOff   = 2'd0;
   localparam logic [ModeW-1:0] ModeOn    = 2'd1;
   localparam logic [ModeW-1:0] ModeAwait = 2'd2;

   // fixed delays, in ticks
   localparam int DropDelay      = 10;
   localparam int ChargeOnDelay  = 10;
   localparam int ChargeOffDelay = 1;

   // countdown slots
   localparam int SlotLoadOn  = 0;
   localparam int SlotLoadOff = 1;
   localparam int SlotSrcOn   = 2;
   localparam int SlotSrcOff  = 3;
   localparam int NumSlots    = 4;

   // configuration register set
   typedef struct packed {
      logic [VoltW-1:0]  charge_start_volt;
      logic [VoltW-1:0]  handover_volt;
      logic [VoltW-1:0]  release_voltage;
      logic [AmpW-1:0]   current_threshold;
      logic [DelayW-1:0] source_on_delay;
      logic [DelayW-1:0] load_on_delay;
      logic [DelayW-1:0] source_off_delay;
   } cfg_type;

endpackage

[rtl/lrs_csr.sv]
// ----------------------------------------------------------------------------
// lrs_csr
// Configuration register file: thresholds and handover delays, written
// through a plain write port, presented to the sequencer as one struct.
// ----------------------------------------------------------------------------
module lrs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [lrs_pkg::CsrIndexW-1:0] csr_index,
   input  logic [lrs_pkg::CsrDataW-1:0]  csr_write_data,
   output lrs_pkg::cfg_type              cfg
);
   import lrs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            RegEmergencyVoltage: cfg_in.charge_start_volt = csr_write_data[VoltW-1:0];
            RegLowVoltage:       cfg_in.handover_volt     = csr_write_data[VoltW-1:0];
            RegReleaseVoltage:   cfg_in.release_voltage   = csr_write_data[VoltW-1:0];
            RegCurrentThreshold: cfg_in.current_threshold = csr_write_data[AmpW-1:0];
            RegSourceOnDelay:    cfg_in.source_on_delay   = csr_write_data[DelayW-1:0];
            RegLoadOnDelay:      cfg_in.load_on_delay     = csr_write_data[DelayW-1:0];
            RegSourceOffDelay:   cfg_in.source_off_delay  = csr_write_data[DelayW-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_start_volt <= EmergencyVoltageRst;
         cfg_ff.handover_volt     <= LowVoltageRst;
         cfg_ff.release_voltage   <= ReleaseVoltageRst;
         cfg_ff.current_threshold <= CurrentThresholdRst;
         cfg_ff.source_on_delay   <= SourceOnDelayRst;
         cfg_ff.load_on_delay     <= LoadOnDelayRst;
         cfg_ff.source_off_delay  <= SourceOffDelayRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lrs_countdown.sv]
// ----------------------------------------------------------------------------
// lrs_countdown
// One-shot countdown slot: loaded by arm, counts down once per tick and
// fires on the tick at which its count is one or less.
// ----------------------------------------------------------------------------
module lrs_countdown #(
   parameter int DELAY_WIDTH = lrs_pkg::DELAY_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick,
   input  logic                   arm,
   input  logic [DELAY_WIDTH-1:0] arm_value,
   output logic                   fire,
   output logic                   armed
);
   import lrs_pkg::*;

   logic                   armed_ff;
   logic                   armed_in;
   logic [DELAY_WIDTH-1:0] count_ff;
   logic [DELAY_WIDTH-1:0] count_in;

   // expiry this tick
   assign fire = tick && armed_ff && (count_ff <= DELAY_WIDTH'(1));

   // advance, then a re-arm on the same tick restarts the slot
   always_comb begin
      armed_in = armed_ff;
      count_in = count_ff;
      if (fire) begin
         armed_in = 1'b0;
         count_in = '0;
      end else if (tick && armed_ff) begin
         count_in = count_ff - DELAY_WIDTH'(1);
      end
      if (arm) begin
         armed_in = 1'b1;
         count_in = arm_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

   assign armed = armed_ff;

   // an expired slot is idle afterwards unless re-armed
   a_fire_disarms: assert property (@(posedge clock) disable iff (reset)
      (fire && !arm) |=> !armed_ff)
      else $error("countdown still armed after expiry");

endmodule

[rtl/load_relay_sequencer_top.sv]
// ----------------------------------------------------------------------------
// load_relay_sequencer_top
// Load relay sequencer: per-tick relay countdowns, load handover and
// emergency charge control.
// ----------------------------------------------------------------------------
// Each request is one 1 ms tick and is taken at a rate of one per clock
// while the response channel does not stall; a request is held in the
// input register, is evaluated against the relay state, the four countdown
// slots and the thresholds in a single pass, and its response is registered
// in the output register. Response stall holds the output register and
// then the input register. Thresholds and delays are written through the
// csr port while no request is in flight; the user must keep to this, as
// the block itself does not enforce it.
module load_relay_sequencer_top #(
   parameter int DELAY_WIDTH = lrs_pkg::DELAY_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [lrs_pkg::VoltW-1:0]     req_battery_voltage,
   input  logic [lrs_pkg::AmpW-1:0]      req_load_current,
   input  logic                          req_emergency_disabled,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_source_relay_on,
   output logic                          rsp_load_relay_on,
   output logic                          rsp_emergency_active,
   output logic [lrs_pkg::ModeW-1:0]     rsp_load_mode,
   // configuration port
   input  logic                          csr_write_enable,
   input  logic [lrs_pkg::CsrIndexW-1:0] csr_index,
   input  logic [lrs_pkg::CsrDataW-1:0]  csr_write_data
);
   import lrs_pkg::*;

   localparam int WideW = (DELAY_WIDTH > DelayW) ? DELAY_WIDTH : DelayW;
   localparam logic [DELAY_WIDTH-1:0] DelayMax = '1;

   // clamp a configured delay to the countdown width
   function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [DelayW-1:0] value);
      logic [WideW-1:0] wide;
      wide = WideW'(value);
      if (wide > WideW'(DelayMax)) begin
         sat_delay = DelayMax;
      end else begin
         sat_delay = DELAY_WIDTH'(wide);
      end
   endfunction

   cfg_type cfg;

   // input register
   logic             in_valid_ff;
   logic             in_valid_in;
   logic             in_kind_ff;
   logic [VoltW-1:0] in_volt_ff;
   logic [AmpW-1:0]  in_amps_ff;
   logic             in_disabled_ff;
   logic             advance;

   // relay state
   logic             emerg_ff, emerg_in;
   logic [ModeW-1:0] load_state_ff, load_state_in;
   logic             source_drive_ff, source_drive_in;
   logic             load_pin_ff, load_pin_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_source_ff, rsp_load_ff, rsp_emerg_ff;
   logic [ModeW-1:0] rsp_mode_ff;

   // countdown slots
   logic [NumSlots-1:0]    slot_arm;
   logic [NumSlots-1:0]    slot_fire;
   logic [NumSlots-1:0]    slot_armed;
   logic [DELAY_WIDTH-1:0] slot_value [NumSlots];

   // management decisions
   logic             manage;
   logic [ModeW-1:0] load_state_mid;
   logic             handover, drop, charge_start, charge_stop;

   lrs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // handshake
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_kind_ff     <= req_kind;
         in_volt_ff     <= req_battery_voltage;
         in_amps_ff     <= req_load_current;
         in_disabled_ff <= req_emergency_disabled;
      end
   end

   // countdowns
   for (genvar s = 0; s < NumSlots; s++) begin : g_slot
      lrs_countdown #(.DELAY_WIDTH(DELAY_WIDTH)) u_countdown (
         .clock     (clock),
         .reset     (reset),
         .tick      (advance),
         .arm       (slot_arm[s]),
         .arm_value (slot_value[s]),
         .fire      (slot_fire[s]),
         .armed     (slot_armed[s])
      );
   end

   // expiries act in slot order, off wins over on for the same relay
   always_comb begin
      load_pin_in     = load_pin_ff;
      load_state_mid  = load_state_ff;
      source_drive_in = source_drive_ff;
      if (slot_fire[SlotLoadOn]) begin
         load_pin_in    = 1'b1;
         load_state_mid = ModeOn;
      end
      if (slot_fire[SlotLoadOff]) begin
         load_pin_in    = 1'b0;
         load_state_mid = ModeOff;
      end
      if (slot_fire[SlotSrcOn]) begin
         source_drive_in = 1'b1;
      end
      if (slot_fire[SlotSrcOff]) begin
         source_drive_in = 1'b0;
      end
   end

   // load handover, then emergency charge
   assign manage   = advance && in_kind_ff;
   assign handover = manage && (load_state_mid == ModeOff)
                     && (in_amps_ff > cfg.current_threshold) && !emerg_ff
                     && (in_volt_ff > cfg.handover_volt);
   assign drop     = manage && !handover && (load_state_mid == ModeOn)
                     && ((in_amps_ff < cfg.current_threshold) || emerg_ff);
   assign charge_start = manage && !in_disabled_ff && !emerg_ff
                         && (in_volt_ff < cfg.charge_start_volt);
   assign charge_stop  = manage && !charge_start && source_drive_in && !in_disabled_ff
                         && emerg_ff && (in_volt_ff > cfg.release_voltage);

   assign load_state_in = handover ? ModeAwait : load_state_mid;
   assign emerg_in      = charge_start ? 1'b1 : (charge_stop ? 1'b0 : emerg_ff);

   // slot arming, a charge start overrides a handover on the source-on slot
   assign slot_arm[SlotLoadOn]  = handover;
   assign slot_arm[SlotLoadOff] = drop;
   assign slot_arm[SlotSrcOn]   = handover || charge_start;
   assign slot_arm[SlotSrcOff]  = handover || charge_stop;

   assign slot_value[SlotLoadOn]  = sat_delay(cfg.load_on_delay);
   assign slot_value[SlotLoadOff] = DELAY_WIDTH'(DropDelay);
   assign slot_value[SlotSrcOn]   = charge_start ? DELAY_WIDTH'(ChargeOnDelay)
                                                 : sat_delay(cfg.source_on_delay);
   assign slot_value[SlotSrcOff]  = charge_stop ? DELAY_WIDTH'(ChargeOffDelay)
                                                : sat_delay(cfg.source_off_delay);

   // relay state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         emerg_ff        <= 1'b0;
         load_state_ff   <= ModeOff;
         source_drive_ff <= 1'b0;
         load_pin_ff     <= 1'b0;
      end else if (advance) begin
         emerg_ff        <= emerg_in;
         load_state_ff   <= load_state_in;
         source_drive_ff <= source_drive_in;
         load_pin_ff     <= load_pin_in;
      end
   end

   // output register
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_source_ff <= source_drive_in;
         rsp_load_ff   <= load_pin_in;
         rsp_emerg_ff  <= emerg_in;
         rsp_mode_ff   <= load_state_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_source_relay_on  = rsp_source_ff;
   assign rsp_load_relay_on    = rsp_load_ff;
   assign rsp_emergency_active = rsp_emerg_ff;
   assign rsp_load_mode        = rsp_mode_ff;

   // a charge only ends with the source relay closed
   a_charge_stop_source: assert property (@(posedge clock) disable iff (reset)
      ($fell(emerg_ff) && !$past(reset)) |-> source_drive_ff)
      else $error("emergency charge ended with source relay open");

   // awaiting load always has its load-on countdown running
   a_await_armed: assert property (@(posedge clock) disable iff (reset)
      (load_state_ff == ModeAwait) |-> slot_armed[SlotLoadOn])
      else $error("load awaiting on without a pending load-on");

   // a new response only comes from a request in the input register
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && !$past(reset)) |-> $past(in_valid_ff))
      else $error("response without a request");

   // stall only when the input register holds a request
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room available");

endmodule
